// ===== rtl/bba_pkg.sv =====
// Shared types, request codes and constants of the bitmap block allocator.
package bba_pkg;

	localparam int unsigned BITMAP_WORDS_DEF = 64;
	localparam int unsigned SCAN_LIMIT       = 64;

	localparam logic [31:0] ALL_USED = 32'hFFFF_FFFF;
	localparam logic [31:0] TOP_BIT  = 32'h8000_0000;
	localparam logic [4:0]  POS_MASK = 5'h1F;

	localparam logic [2:0] REQ_ALLOC = 3'd0;
	localparam logic [2:0] REQ_FREE  = 3'd1;
	localparam logic [2:0] REQ_CHECK = 3'd2;
	localparam logic [2:0] REQ_LOAD  = 3'd3;
	localparam logic [2:0] REQ_READ  = 3'd4;

	localparam logic ST_OK   = 1'b0;
	localparam logic ST_FAIL = 1'b1;

	typedef struct packed {
		logic       found;
		logic [4:0] pos;
	} bba_find_t;

endpackage

// ===== rtl/bba_mem.sv =====
// Bitmap word memory: one write or read per cycle, registered read data.
module bba_mem #(
	parameter int unsigned WORDS = 64,
	parameter int unsigned AW    = 6
) (
	input  logic          clk,
	input  logic          we,
	input  logic          re,
	input  logic [AW-1:0] addr,
	input  logic [31:0]   wdata,
	output logic [31:0]   rdata
);

	logic [31:0] mem_q [WORDS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

// ===== rtl/bba_find.sv =====
// First clear bit of a bitmap word, searched from the MSB down.
module bba_find (
	input  logic [31:0]          word,
	output bba_pkg::bba_find_t   res
);
	import bba_pkg::*;

	logic [31:0] v0;
	logic [31:0] v1;
	logic [31:0] v2;
	logic [31:0] v3;
	logic [31:0] v4;
	logic [4:0]  n;

	always_comb begin
		v0 = ~word;
		n[4] = (v0[31:16] == 16'h0);
		v1 = n[4] ? {v0[15:0], 16'h0} : v0;
		n[3] = (v1[31:24] == 8'h0);
		v2 = n[3] ? {v1[23:0], 8'h0} : v1;
		n[2] = (v2[31:28] == 4'h0);
		v3 = n[2] ? {v2[27:0], 4'h0} : v2;
		n[1] = (v3[31:30] == 2'h0);
		v4 = n[1] ? {v3[29:0], 2'h0} : v3;
		n[0] = ~v4[31];
		res.found = (word != ALL_USED);
		res.pos   = n & POS_MASK;
	end

endmodule

// ===== rtl/bba_ctrl.sv =====
// Request sequencer: clearing pass, read-modify-write, allocate scan, result register.
module bba_ctrl #(
	parameter int unsigned WORDS = 64,
	parameter int unsigned AW    = 6
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [2:0]          req_type,
	input  logic [10:0]         block_index,
	input  logic [5:0]          word_index,
	input  logic [31:0]         word_value,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                status,
	output logic [10:0]         granted_block,
	output logic                block_in_use,
	output logic [31:0]         word_out,
	output logic                mem_we,
	output logic                mem_re,
	output logic [AW-1:0]       mem_addr,
	output logic [31:0]         mem_wdata,
	input  logic [31:0]         mem_rdata,
	input  bba_pkg::bba_find_t  find
);
	import bba_pkg::*;

	localparam int unsigned SCAN_WORDS = (WORDS < SCAN_LIMIT) ? WORDS : SCAN_LIMIT;
	localparam logic [AW-1:0] LAST_WORD = AW'(WORDS - 1);
	localparam logic [AW-1:0] LAST_SCAN = AW'(SCAN_WORDS - 1);

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_RD    = 5'b00100,
		ST_MOD   = 5'b01000,
		ST_RESP  = 5'b10000
	} bba_state_t;

	bba_state_t  state_q, state_d;
	logic        fs_enabled_q;
	logic [2:0]  typ_q, typ_d;
	logic [AW-1:0] addr_q, addr_d;
	logic [31:0] mask_q, mask_d;
	logic [31:0] wval_q, wval_d;
	logic        res_status_q, res_status_d;
	logic [10:0] res_granted_q, res_granted_d;
	logic        res_use_q, res_use_d;
	logic [31:0] res_word_q, res_word_d;
	logic        out_valid_q;
	logic        status_q;
	logic [10:0] granted_q;
	logic        use_q;
	logic [31:0] word_q;

	logic        accept;
	logic        out_free;
	logic        out_load;
	logic [5:0]  blk_word;
	logic        blk_in;
	logic        wrd_in;
	logic        req_ok;
	logic [5:0]  sel_word;
	logic [31:0] sel_ext;
	logic [31:0] scan_ext;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_load  = (state_q == ST_RESP) && out_free;

	assign blk_word = block_index[10:5];
	assign blk_in   = (32'(blk_word) < 32'(WORDS));
	assign wrd_in   = (32'(word_index) < 32'(WORDS));
	assign scan_ext = 32'(addr_q);

	always_comb begin
		unique case (req_type)
			REQ_ALLOC: begin
				req_ok   = fs_enabled_q;
				sel_word = 6'd0;
			end
			REQ_FREE: begin
				req_ok   = fs_enabled_q && blk_in;
				sel_word = blk_word;
			end
			REQ_CHECK: begin
				req_ok   = blk_in;
				sel_word = blk_word;
			end
			REQ_LOAD, REQ_READ: begin
				req_ok   = wrd_in;
				sel_word = word_index;
			end
			default: begin
				req_ok   = 1'b0;
				sel_word = 6'd0;
			end
		endcase
		sel_ext = 32'(sel_word);
	end

	always_comb begin
		state_d       = state_q;
		typ_d         = typ_q;
		addr_d        = addr_q;
		mask_d        = mask_q;
		wval_d        = wval_q;
		res_status_d  = res_status_q;
		res_granted_d = res_granted_q;
		res_use_d     = res_use_q;
		res_word_d    = res_word_q;
		mem_we        = 1'b0;
		mem_re        = 1'b0;
		mem_addr      = addr_q;
		mem_wdata     = 32'h0;

		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				addr_d = addr_q + AW'(1);
				if (addr_q == LAST_WORD) begin
					addr_d  = '0;
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					typ_d         = req_type;
					addr_d        = sel_ext[AW-1:0];
					mask_d        = TOP_BIT >> (block_index[4:0] & POS_MASK);
					wval_d        = word_value;
					res_status_d  = ST_FAIL;
					res_granted_d = 11'd0;
					res_use_d     = 1'b0;
					res_word_d    = 32'h0;
					state_d       = req_ok ? ST_RD : ST_RESP;
				end
			end
			ST_RD: begin
				if (typ_q == REQ_LOAD) begin
					mem_we       = 1'b1;
					mem_wdata    = wval_q;
					res_status_d = ST_OK;
					state_d      = ST_RESP;
				end else begin
					mem_re  = 1'b1;
					state_d = ST_MOD;
				end
			end
			ST_MOD: begin
				state_d = ST_RESP;
				unique case (typ_q)
					REQ_ALLOC: begin
						if (find.found) begin
							mem_we        = 1'b1;
							mem_wdata     = mem_rdata | (TOP_BIT >> find.pos);
							res_status_d  = ST_OK;
							res_granted_d = {scan_ext[5:0], find.pos};
						end else if (addr_q != LAST_SCAN) begin
							addr_d   = addr_q + AW'(1);
							mem_re   = 1'b1;
							mem_addr = addr_q + AW'(1);
							state_d  = ST_MOD;
						end
					end
					REQ_FREE: begin
						mem_we       = 1'b1;
						mem_wdata    = mem_rdata & ~mask_q;
						res_status_d = ST_OK;
					end
					REQ_CHECK: begin
						res_status_d = ST_OK;
						res_use_d    = |(mem_rdata & mask_q);
					end
					REQ_READ: begin
						res_status_d = ST_OK;
						res_word_d   = mem_rdata;
					end
					default: begin
						res_status_d = ST_FAIL;
					end
				endcase
			end
			ST_RESP: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			addr_q       <= '0;
			fs_enabled_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			addr_q  <= addr_d;
			if (cfg_valid && cfg_ready) begin
				fs_enabled_q <= cfg_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		typ_q         <= typ_d;
		mask_q        <= mask_d;
		wval_q        <= wval_d;
		res_status_q  <= res_status_d;
		res_granted_q <= res_granted_d;
		res_use_q     <= res_use_d;
		res_word_q    <= res_word_d;
		if (out_load) begin
			status_q  <= res_status_q;
			granted_q <= res_granted_q;
			use_q     <= res_use_q;
			word_q    <= res_word_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign granted_block = granted_q;
	assign block_in_use  = use_q;
	assign word_out      = word_q;

	a_accept_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> in_stall)
		else $error("request accepted while another is in flight");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q != ST_IDLE))
		else $error("bitmap written with no request in flight");

	a_resp_loads: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (out_valid_q && (state_q == ST_IDLE)))
		else $error("result not registered on leaving response state");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (status_q == ST_FAIL)) |->
		((granted_q == 11'd0) && !use_q && (word_q == 32'h0)))
		else $error("failed request carries a non-zero field");

	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_MOD) && (typ_q == REQ_ALLOC)) |-> (scan_ext < 32'(SCAN_WORDS)))
		else $error("allocate scan beyond range");

endmodule

// ===== rtl/bitmap_block_allocator_core.sv =====
// Top level of the bitmap first-fit block allocator.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------------
//  cfg     | in        | cfg_valid, cfg_ready | cfg_data (fs_enabled)
//  in      | in        | in_valid, in_stall   | req_type, block_index, word_index, word_value
//  out     | out       | out_valid, out_stall | status, granted_block, block_in_use, word_out
//
//  One request at a time. Load writes in ST_RD and then answers from ST_RESP; free,
//  check and read pass ST_RD, ST_MOD and ST_RESP; allocate reads the bitmap in ST_RD
//  and ST_MOD, one memory read a cycle, at most min(BITMAP_WORDS, 64) words, a full
//  bitmap included; a request refused on acceptance (disabled, index beyond bitmap,
//  unknown type) goes straight to ST_RESP. After reset a clearing pass zeroes the
//  bitmap memory with in_stall high; cfg writes are taken throughout.
//  A stalled result holds in the output register while the next request is taken.
module bitmap_block_allocator_core #(
	parameter int unsigned BITMAP_WORDS = bba_pkg::BITMAP_WORDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  req_type,
	input  logic [10:0] block_index,
	input  logic [5:0]  word_index,
	input  logic [31:0] word_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        status,
	output logic [10:0] granted_block,
	output logic        block_in_use,
	output logic [31:0] word_out
);
	import bba_pkg::*;

	localparam int unsigned AW = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;

	logic          mem_we;
	logic          mem_re;
	logic [AW-1:0] mem_addr;
	logic [31:0]   mem_wdata;
	logic [31:0]   mem_rdata;
	bba_find_t     find;

	bba_mem #(
		.WORDS (BITMAP_WORDS),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.re    (mem_re),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	bba_find u_find (
		.word (mem_rdata),
		.res  (find)
	);

	bba_ctrl #(
		.WORDS (BITMAP_WORDS),
		.AW    (AW)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.req_type      (req_type),
		.block_index   (block_index),
		.word_index    (word_index),
		.word_value    (word_value),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.granted_block (granted_block),
		.block_in_use  (block_in_use),
		.word_out      (word_out),
		.mem_we        (mem_we),
		.mem_re        (mem_re),
		.mem_addr      (mem_addr),
		.mem_wdata     (mem_wdata),
		.mem_rdata     (mem_rdata),
		.find          (find)
	);

endmodule
